FILE: src/swhf_pkg.sv
// ----------------------------------------------------------------------------
// Spherical wall haptic force package
// Shared widths, register indexes and pipeline tag types.
// ----------------------------------------------------------------------------
package swhf_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int POS_W      = 32;
   localparam int DIFF_W     = POS_W + 1;
   localparam int SQ_W       = 2 * DIFF_W;
   localparam int SUM_W      = SQ_W + 1;
   localparam int RAD_W      = 31;
   localparam int RAD2_W     = 2 * RAD_W;
   localparam int ROOT_W     = RAD_W;
   localparam int REM_W      = ROOT_W + 2;
   localparam int PROD_W     = 2 * RAD_W;
   localparam int NUM_W      = 64;
   localparam int QUO_W      = RAD_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Z    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STIFFNESS   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FORCE_LIMIT = 3'd5;

   // Geometry carried alongside the square root.
   typedef struct packed {
      logic [DIFF_W-1:0] mag_x;
      logic [DIFF_W-1:0] mag_y;
      logic [DIFF_W-1:0] mag_z;
      logic [2:0]        neg;
      logic              outside;
      logic              surface;
      logic              center;
   } geo_tag_type;

   // Flags carried alongside the dividers.
   typedef struct packed {
      logic [2:0] neg;
      logic       outside;
      logic       surface;
      logic       center;
   } out_tag_type;

endpackage

FILE: src/swhf_if.sv
// ----------------------------------------------------------------------------
// Spherical wall haptic force channels
// Valid/ready channels for position samples and force results.
// ----------------------------------------------------------------------------
interface swhf_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] pos_x;
   logic [31:0] pos_y;
   logic [31:0] pos_z;
   modport source (output valid, pos_x, pos_y, pos_z, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface swhf_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] force_x;
   logic [31:0] force_y;
   logic [31:0] force_z;
   logic        in_contact;
   modport source (output valid, force_x, force_y, force_z, in_contact, input ready);
   modport sink (input valid, force_x, force_y, force_z, in_contact, output ready);
endinterface

FILE: src/swhf_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per stage, restoring digit-by-digit method.
// ----------------------------------------------------------------------------
module swhf_sqrt (
   input  logic                          clock,
   input  logic                          advance,
   input  logic [swhf_pkg::RAD2_W-1:0]   radicand,
   output logic [swhf_pkg::ROOT_W-1:0]   root
);
   localparam int N = swhf_pkg::ROOT_W;

   logic [swhf_pkg::RAD2_W-1:0] rad_ff  [N];
   logic [swhf_pkg::REM_W-1:0]  rem_ff  [N];
   logic [N-1:0]                root_ff [N];

   for (genvar j = 0; j < N; j++) begin : g_stage
      logic [swhf_pkg::RAD2_W-1:0] rad_prev;
      logic [swhf_pkg::REM_W-1:0]  rem_prev;
      logic [N-1:0]                root_prev;
      logic [swhf_pkg::REM_W+1:0]  cur;
      logic [swhf_pkg::REM_W+1:0]  trial;
      logic [swhf_pkg::REM_W+1:0]  diff;

      if (j == 0) begin : g_first
         assign rad_prev  = radicand;
         assign rem_prev  = '0;
         assign root_prev = '0;
      end else begin : g_next
         assign rad_prev  = rad_ff[j-1];
         assign rem_prev  = rem_ff[j-1];
         assign root_prev = root_ff[j-1];
      end

      always_comb begin
         cur   = {rem_prev, rad_prev[2*(N-1-j)+1 -: 2]};
         trial = (swhf_pkg::REM_W+2)'({root_prev, 2'b01});
         diff  = cur - trial;
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rad_ff[j] <= rad_prev;
            if (cur >= trial) begin
               rem_ff[j]  <= diff[swhf_pkg::REM_W-1:0];
               root_ff[j] <= {root_prev[N-2:0], 1'b1};
            end else begin
               rem_ff[j]  <= cur[swhf_pkg::REM_W-1:0];
               root_ff[j] <= {root_prev[N-2:0], 1'b0};
            end
         end
      end
   end

   assign root = root_ff[N-1];

endmodule

FILE: src/swhf_div.sv
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// One quotient bit per stage; the quotient is known to fit QUO_W bits.
// ----------------------------------------------------------------------------
module swhf_div (
   input  logic                         clock,
   input  logic                         advance,
   input  logic [swhf_pkg::NUM_W-1:0]   numer,
   input  logic [swhf_pkg::RAD_W-1:0]   denom,
   output logic [swhf_pkg::QUO_W-1:0]   quot
);
   localparam int N = swhf_pkg::QUO_W;

   logic [swhf_pkg::NUM_W-1:0] rem_ff [N];
   logic [swhf_pkg::RAD_W-1:0] den_ff [N];
   logic [N-1:0]               quo_ff [N];

   for (genvar j = 0; j < N; j++) begin : g_stage
      logic [swhf_pkg::NUM_W-1:0] rem_prev;
      logic [swhf_pkg::RAD_W-1:0] den_prev;
      logic [N-1:0]               quo_prev;
      logic [swhf_pkg::NUM_W-1:0] den_shift;

      if (j == 0) begin : g_first
         assign rem_prev = numer;
         assign den_prev = denom;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign den_prev = den_ff[j-1];
         assign quo_prev = quo_ff[j-1];
      end

      assign den_shift = swhf_pkg::NUM_W'(den_prev) << (N - 1 - j);

      always_ff @(posedge clock) begin
         if (advance) begin
            den_ff[j] <= den_prev;
            if (rem_prev >= den_shift) begin
               rem_ff[j] <= rem_prev - den_shift;
               quo_ff[j] <= {quo_prev[N-2:0], 1'b1};
            end else begin
               rem_ff[j] <= rem_prev;
               quo_ff[j] <= {quo_prev[N-2:0], 1'b0};
            end
         end
      end
   end

   assign quot = quo_ff[N-1];

endmodule

FILE: src/spherical_wall_haptic_force.sv
// ----------------------------------------------------------------------------
// Spherical wall haptic force
// Renders a spring force from a virtual spherical wall for each tool position.
// ----------------------------------------------------------------------------
// Throughput: one position per cycle unless the output stalls; the 31-stage
// square root and the three 31-stage dividers each take a new operand every cycle that the pipeline advances.
// A position exactly on the sphere surface produces no response.
// Reset (synchronous, active high) clears all valid bits and the configuration registers.
// ----------------------------------------------------------------------------
module spherical_wall_haptic_force (
   input  logic                              clock,
   input  logic                              reset,
   swhf_req_if.sink                          req_chan,
   swhf_rsp_if.source                        rsp_chan,
   input  logic                              csr_we,
   input  logic [swhf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [swhf_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   localparam int SQ_N  = swhf_pkg::ROOT_W;
   localparam int DIV_N = swhf_pkg::QUO_W;

   // Configuration registers. The user must change them only while the pipeline
   // is empty; the block does not enforce this, and every stage reads them directly.
   logic [31:0]                center_x_ff, center_y_ff, center_z_ff;
   logic [swhf_pkg::RAD_W-1:0] radius_ff, stiffness_ff, force_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff    <= '0;
         center_y_ff    <= '0;
         center_z_ff    <= '0;
         radius_ff      <= '0;
         stiffness_ff   <= '0;
         force_limit_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            swhf_pkg::CSR_CENTER_X:    center_x_ff    <= csr_wdata;
            swhf_pkg::CSR_CENTER_Y:    center_y_ff    <= csr_wdata;
            swhf_pkg::CSR_CENTER_Z:    center_z_ff    <= csr_wdata;
            swhf_pkg::CSR_RADIUS:      radius_ff      <= csr_wdata[swhf_pkg::RAD_W-1:0];
            swhf_pkg::CSR_STIFFNESS:   stiffness_ff   <= csr_wdata[swhf_pkg::RAD_W-1:0];
            swhf_pkg::CSR_FORCE_LIMIT: force_limit_ff <= csr_wdata[swhf_pkg::RAD_W-1:0];
            default: ;
         endcase
      end
   end

   // The whole pipeline moves together; it holds only when the output
   // register is full and the consumer is not taking a transfer.
   logic rsp_valid_ff;
   logic advance;
   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   // Stage 0: offsets from the center as sign and magnitude.
   logic signed [swhf_pkg::DIFF_W-1:0] dx, dy, dz;
   logic [swhf_pkg::DIFF_W-1:0]        mx_in, my_in, mz_in;
   logic [swhf_pkg::DIFF_W-1:0]        mx_ff, my_ff, mz_ff;
   logic [2:0]                         neg0_ff;
   logic                               v0_ff;

   always_comb begin
      dx    = $signed({req_chan.pos_x[31], req_chan.pos_x})
            - $signed({center_x_ff[31], center_x_ff});
      dy    = $signed({req_chan.pos_y[31], req_chan.pos_y})
            - $signed({center_y_ff[31], center_y_ff});
      dz    = $signed({req_chan.pos_z[31], req_chan.pos_z})
            - $signed({center_z_ff[31], center_z_ff});
      mx_in = dx[swhf_pkg::DIFF_W-1] ? swhf_pkg::DIFF_W'(-dx) : swhf_pkg::DIFF_W'(dx);
      my_in = dy[swhf_pkg::DIFF_W-1] ? swhf_pkg::DIFF_W'(-dy) : swhf_pkg::DIFF_W'(dy);
      mz_in = dz[swhf_pkg::DIFF_W-1] ? swhf_pkg::DIFF_W'(-dz) : swhf_pkg::DIFF_W'(dz);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mx_ff   <= mx_in;
         my_ff   <= my_in;
         mz_ff   <= mz_in;
         neg0_ff <= {dz[swhf_pkg::DIFF_W-1], dy[swhf_pkg::DIFF_W-1], dx[swhf_pkg::DIFF_W-1]};
      end
   end

   // Stage 1: squares of the offsets and of the radius.
   logic [swhf_pkg::SQ_W-1:0]   sx_ff, sy_ff, sz_ff;
   logic [swhf_pkg::RAD2_W-1:0] r2_ff;
   logic [swhf_pkg::DIFF_W-1:0] mx1_ff, my1_ff, mz1_ff;
   logic [2:0]                  neg1_ff;
   logic                        v1_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         sx_ff   <= swhf_pkg::SQ_W'(mx_ff) * swhf_pkg::SQ_W'(mx_ff);
         sy_ff   <= swhf_pkg::SQ_W'(my_ff) * swhf_pkg::SQ_W'(my_ff);
         sz_ff   <= swhf_pkg::SQ_W'(mz_ff) * swhf_pkg::SQ_W'(mz_ff);
         r2_ff   <= swhf_pkg::RAD2_W'(radius_ff) * swhf_pkg::RAD2_W'(radius_ff);
         mx1_ff  <= mx_ff;
         my1_ff  <= my_ff;
         mz1_ff  <= mz_ff;
         neg1_ff <= neg0_ff;
      end
   end

   // Stage 2: squared distance.
   logic [swhf_pkg::SUM_W-1:0]  sum_ff;
   logic [swhf_pkg::RAD2_W-1:0] r2b_ff;
   logic [swhf_pkg::DIFF_W-1:0] mx2_ff, my2_ff, mz2_ff;
   logic [2:0]                  neg2_ff;
   logic                        v2_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         sum_ff  <= swhf_pkg::SUM_W'(sx_ff) + swhf_pkg::SUM_W'(sy_ff)
                  + swhf_pkg::SUM_W'(sz_ff);
         r2b_ff  <= r2_ff;
         mx2_ff  <= mx1_ff;
         my2_ff  <= my1_ff;
         mz2_ff  <= mz1_ff;
         neg2_ff <= neg1_ff;
      end
   end

   // Stage 3: classify against the sphere. Inside, the squared distance is
   // below the squared radius, so it fits the root's radicand width.
   swhf_pkg::geo_tag_type        tag3_ff;
   logic [swhf_pkg::RAD2_W-1:0]  rad3_ff;
   logic                         v3_ff;
   logic [swhf_pkg::SUM_W-1:0]   r2_ext;
   assign r2_ext = swhf_pkg::SUM_W'(r2b_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         tag3_ff.mag_x   <= mx2_ff;
         tag3_ff.mag_y   <= my2_ff;
         tag3_ff.mag_z   <= mz2_ff;
         tag3_ff.neg     <= neg2_ff;
         tag3_ff.outside <= sum_ff > r2_ext;
         tag3_ff.surface <= sum_ff == r2_ext;
         tag3_ff.center  <= sum_ff == '0;
         rad3_ff         <= sum_ff[swhf_pkg::RAD2_W-1:0];
      end
   end

   // Square root, with the geometry tags riding along.
   logic [swhf_pkg::ROOT_W-1:0] root;
   swhf_pkg::geo_tag_type       tag_sq_ff [SQ_N];
   logic [SQ_N-1:0]             v_sq_ff;

   swhf_sqrt u_sqrt (
      .clock    (clock),
      .advance  (advance),
      .radicand (rad3_ff),
      .root     (root)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         tag_sq_ff[0] <= tag3_ff;
         for (int j = 1; j < SQ_N; j++) begin
            tag_sq_ff[j] <= tag_sq_ff[j-1];
         end
      end
   end

   // Stage P: spring force before the limit.
   logic [swhf_pkg::PROD_W-1:0] prod_ff;
   logic [swhf_pkg::ROOT_W-1:0] dp_ff;
   swhf_pkg::geo_tag_type       tagp_ff;
   logic                        vp_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= swhf_pkg::PROD_W'(stiffness_ff)
                  * swhf_pkg::PROD_W'(radius_ff - root);
         dp_ff   <= root;
         tagp_ff <= tag_sq_ff[SQ_N-1];
      end
   end

   // Stage Q: apply the force limit.
   logic [swhf_pkg::PROD_W-1:0] mag_shift;
   logic [swhf_pkg::RAD_W-1:0]  mq_ff;
   logic [swhf_pkg::ROOT_W-1:0] dq_ff;
   swhf_pkg::geo_tag_type       tagq_ff;
   logic                        vq_ff;

   assign mag_shift = prod_ff >> swhf_pkg::FRAC_BITS;

   always_ff @(posedge clock) begin
      if (advance) begin
         mq_ff   <= (mag_shift > swhf_pkg::PROD_W'(force_limit_ff))
                  ? force_limit_ff : mag_shift[swhf_pkg::RAD_W-1:0];
         dq_ff   <= dp_ff;
         tagq_ff <= tagp_ff;
      end
   end

   // Stage N: numerators of the three components.
   logic [swhf_pkg::NUM_W-1:0]  nx_ff, ny_ff, nz_ff;
   logic [swhf_pkg::ROOT_W-1:0] dn_ff;
   swhf_pkg::out_tag_type       tagn_ff;
   logic                        vn_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         nx_ff           <= swhf_pkg::NUM_W'(tagq_ff.mag_x) * swhf_pkg::NUM_W'(mq_ff);
         ny_ff           <= swhf_pkg::NUM_W'(tagq_ff.mag_y) * swhf_pkg::NUM_W'(mq_ff);
         nz_ff           <= swhf_pkg::NUM_W'(tagq_ff.mag_z) * swhf_pkg::NUM_W'(mq_ff);
         dn_ff           <= dq_ff;
         tagn_ff.neg     <= tagq_ff.neg;
         tagn_ff.outside <= tagq_ff.outside;
         tagn_ff.surface <= tagq_ff.surface;
         tagn_ff.center  <= tagq_ff.center;
      end
   end

   // Dividers. At the center the divisor is zero; that quotient is unused.
   logic [swhf_pkg::QUO_W-1:0] qx, qy, qz;
   swhf_pkg::out_tag_type      tag_dv_ff [DIV_N];
   logic [DIV_N-1:0]           v_dv_ff;

   swhf_div u_div_x (.clock(clock), .advance(advance), .numer(nx_ff), .denom(dn_ff), .quot(qx));
   swhf_div u_div_y (.clock(clock), .advance(advance), .numer(ny_ff), .denom(dn_ff), .quot(qy));
   swhf_div u_div_z (.clock(clock), .advance(advance), .numer(nz_ff), .denom(dn_ff), .quot(qz));

   always_ff @(posedge clock) begin
      if (advance) begin
         tag_dv_ff[0] <= tagn_ff;
         for (int j = 1; j < DIV_N; j++) begin
            tag_dv_ff[j] <= tag_dv_ff[j-1];
         end
      end
   end

   // Valid bits for every stage, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff   <= 1'b0;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         v_sq_ff <= '0;
         vp_ff   <= 1'b0;
         vq_ff   <= 1'b0;
         vn_ff   <= 1'b0;
         v_dv_ff <= '0;
      end else if (advance) begin
         v0_ff   <= req_chan.valid;
         v1_ff   <= v0_ff;
         v2_ff   <= v1_ff;
         v3_ff   <= v2_ff;
         v_sq_ff <= {v_sq_ff[SQ_N-2:0], v3_ff};
         vp_ff   <= v_sq_ff[SQ_N-1];
         vq_ff   <= vp_ff;
         vn_ff   <= vq_ff;
         v_dv_ff <= {v_dv_ff[DIV_N-2:0], vn_ff};
      end
   end

   // Output register. A surface hit is dropped here; outside and center
   // cases force the components to zero.
   swhf_pkg::out_tag_type tag_o;
   logic                  zero_force;
   logic                  rsp_valid_in;
   logic [31:0]           fx_in, fy_in, fz_in;
   logic [31:0]           fx_ff, fy_ff, fz_ff;
   logic                  contact_ff;

   always_comb begin
      tag_o        = tag_dv_ff[DIV_N-1];
      zero_force   = tag_o.outside || tag_o.center;
      rsp_valid_in = v_dv_ff[DIV_N-1] && !tag_o.surface;
      fx_in = zero_force ? '0 : (tag_o.neg[0] ? -(32'(qx)) : 32'(qx));
      fy_in = zero_force ? '0 : (tag_o.neg[1] ? -(32'(qy)) : 32'(qy));
      fz_in = zero_force ? '0 : (tag_o.neg[2] ? -(32'(qz)) : 32'(qz));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fx_ff      <= fx_in;
         fy_ff      <= fy_in;
         fz_ff      <= fz_in;
         contact_ff <= !tag_o.outside;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.force_x    = fx_ff;
   assign rsp_chan.force_y    = fy_ff;
   assign rsp_chan.force_z    = fz_ff;
   assign rsp_chan.in_contact = contact_ff;

endmodule

FILE: src/swhf_checker.sv
// ----------------------------------------------------------------------------
// Spherical wall haptic force checker
// Port-level properties of the force pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module swhf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] force_x,
   input logic [31:0] force_y,
   input logic [31:0] force_z,
   input logic        in_contact
);

   // A response waiting without a transfer stays the same.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(force_x) && $stable(force_y)
         && $stable(force_z) && $stable(in_contact))
      else $error("stalled response changed");

   // Outside the sphere the force is zero.
   a_out_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !in_contact |-> force_x == '0 && force_y == '0 && force_z == '0)
      else $error("nonzero force without contact");

   // The pipeline holds exactly when the output is stalled.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not follow output stall");

   // Nothing comes out right after reset.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind spherical_wall_haptic_force swhf_checker u_swhf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .force_x    (rsp_chan.force_x),
   .force_y    (rsp_chan.force_y),
   .force_z    (rsp_chan.force_z),
   .in_contact (rsp_chan.in_contact)
);
